>>> hdl/gij_pkg.sv
// ============================================================================
// gij_pkg
// Types and constants shared by the genomic interval joiner modules.
// ============================================================================
package gij_pkg;

    localparam int CHROM_W   = 16;
    localparam int POS_W     = 31;
    localparam int LEN_W     = 33;
    localparam int CNT_W     = 32;
    localparam int JOIN_W    = 20;
    localparam int FILT_W    = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 272;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_JOIN_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

    // Register values after reset.
    localparam logic [JOIN_W-1:0] JOIN_DISTANCE_RST = 20'd0;
    localparam logic [FILT_W-1:0] MIN_LENGTH_RST    = 24'd4;
    localparam logic [FILT_W-1:0] MAX_LENGTH_RST    = 24'd1000000;

    // Input item kinds, carried on tuser.
    localparam logic FUNC_INTERVAL = 1'b0;
    localparam logic FUNC_FLUSH    = 1'b1;

    // Interval fields of an input word, first field in the lowest bits.
    typedef struct packed {
        logic [POS_W-1:0]   end_pos;
        logic [POS_W-1:0]   start_pos;
        logic [CHROM_W-1:0] chrom_id;
    } in_data_t;

    typedef struct packed {
        logic     func;
        in_data_t data;
    } item_t;

    // Result fields of an output word, first field in the lowest bits.
    typedef struct packed {
        logic [CNT_W-1:0]        long_rejects;
        logic [CNT_W-1:0]        short_rejects;
        logic [CNT_W-1:0]        closed_count;
        logic [CNT_W-1:0]        inputs_seen;
        logic signed [LEN_W-1:0] out_length;
        logic [POS_W-1:0]        out_end;
        logic [POS_W-1:0]        out_start;
        logic [CHROM_W-1:0]      out_chrom;
        logic [CNT_W-1:0]        line_number;
    } out_data_t;

    typedef struct packed {
        logic      record_valid;
        out_data_t data;
    } result_t;

    typedef struct packed {
        logic [JOIN_W-1:0] join_distance;
        logic [FILT_W-1:0] min_merged_length;
        logic [FILT_W-1:0] max_merged_length;
    } cfg_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

>>> hdl/gij_core.sv
// ============================================================================
// gij_core
// Held interval, join decision, length filter and saturating counters.
// ============================================================================
module gij_core #(
    parameter int CHROM_ID_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  gij_pkg::item_t  item,
    input  gij_pkg::cfg_t   cfg,
    output gij_pkg::result_t result
);
    import gij_pkg::*;

    // Chromosome ids are compared in their low CHROM_ID_BITS bits only, at most CHROM_W.
    localparam int HC_W = (CHROM_ID_BITS < CHROM_W) ? CHROM_ID_BITS : CHROM_W;

    logic            held_valid_reg, held_valid_next;
    logic [HC_W-1:0] held_chrom_reg, held_chrom_next;
    logic [POS_W-1:0] held_start_reg, held_start_next;
    logic [POS_W-1:0] held_end_reg, held_end_next;
    logic [CNT_W-1:0] input_cnt_reg, input_cnt_next;
    logic [CNT_W-1:0] closed_cnt_reg, closed_cnt_next;
    logic [CNT_W-1:0] short_cnt_reg, short_cnt_next;
    logic [CNT_W-1:0] long_cnt_reg, long_cnt_next;
    logic [CNT_W-1:0] accept_cnt_reg, accept_cnt_next;

    logic [HC_W-1:0]         in_chrom;
    logic                    join_off;
    logic                    far_gap;
    logic                    close_en;
    logic [HC_W-1:0]         cl_chrom;
    logic [POS_W-1:0]        cl_start;
    logic [POS_W-1:0]        cl_end;
    logic signed [LEN_W-1:0] cl_len;
    logic                    too_short;
    logic                    too_long;
    logic                    emit;

    assign in_chrom = item.data.chrom_id[HC_W-1:0];
    assign join_off = (cfg.join_distance == '0);

    // start - held_end - 1 > join_distance, with all terms non-negative.
    assign far_gap = {2'b00, item.data.start_pos} >
                     ({2'b00, held_end_reg} + LEN_W'(cfg.join_distance) + LEN_W'(1));

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_chrom_next = held_chrom_reg;
        held_start_next = held_start_reg;
        held_end_next   = held_end_reg;
        input_cnt_next  = input_cnt_reg;
        close_en        = 1'b0;
        cl_chrom        = held_chrom_reg;
        cl_start        = held_start_reg;
        cl_end          = held_end_reg;
        if (item.func == FUNC_FLUSH)
        begin
            close_en        = held_valid_reg;
            held_valid_next = 1'b0;
        end
        else
        begin
            input_cnt_next = sat_inc(input_cnt_reg);
            if (join_off)
            begin
                close_en = 1'b1;
                cl_chrom = in_chrom;
                cl_start = item.data.start_pos;
                cl_end   = item.data.end_pos;
            end
            else if (!held_valid_reg || in_chrom != held_chrom_reg || far_gap)
            begin
                close_en        = held_valid_reg;
                held_valid_next = 1'b1;
                held_chrom_next = in_chrom;
                held_start_next = item.data.start_pos;
                held_end_next   = item.data.end_pos;
            end
            else
            begin
                held_end_next = item.data.end_pos;
            end
        end
    end

    assign cl_len    = $signed({2'b00, cl_end}) - $signed({2'b00, cl_start}) + LEN_W'(1);
    assign too_short = cl_len < $signed(LEN_W'(cfg.min_merged_length));
    assign too_long  = cl_len > $signed(LEN_W'(cfg.max_merged_length));
    assign emit      = close_en && !too_short && !too_long;

    always_comb
    begin
        closed_cnt_next = close_en ? sat_inc(closed_cnt_reg) : closed_cnt_reg;
        short_cnt_next  = (close_en && too_short) ? sat_inc(short_cnt_reg) : short_cnt_reg;
        long_cnt_next   = (close_en && !too_short && too_long) ?
                          sat_inc(long_cnt_reg) : long_cnt_reg;
        accept_cnt_next = emit ? sat_inc(accept_cnt_reg) : accept_cnt_reg;
    end

    always_comb
    begin
        result                    = '0;
        result.record_valid       = emit;
        result.data.inputs_seen   = input_cnt_next;
        result.data.closed_count  = closed_cnt_next;
        result.data.short_rejects = short_cnt_next;
        result.data.long_rejects  = long_cnt_next;
        if (emit)
        begin
            result.data.line_number = accept_cnt_next;
            result.data.out_chrom   = CHROM_W'(cl_chrom);
            result.data.out_start   = cl_start;
            result.data.out_end     = cl_end;
            result.data.out_length  = cl_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_chrom_reg <= '0;
            held_start_reg <= '0;
            held_end_reg   <= '0;
            input_cnt_reg  <= '0;
            closed_cnt_reg <= '0;
            short_cnt_reg  <= '0;
            long_cnt_reg   <= '0;
            accept_cnt_reg <= '0;
        end
        else if (step)
        begin
            held_valid_reg <= held_valid_next;
            held_chrom_reg <= held_chrom_next;
            held_start_reg <= held_start_next;
            held_end_reg   <= held_end_next;
            input_cnt_reg  <= input_cnt_next;
            closed_cnt_reg <= closed_cnt_next;
            short_cnt_reg  <= short_cnt_next;
            long_cnt_reg   <= long_cnt_next;
            accept_cnt_reg <= accept_cnt_next;
        end
    end

endmodule

>>> hdl/genomic_interval_joiner.sv
// ============================================================================
// genomic_interval_joiner
// Joins sorted genomic intervals that lie close together and filters the
// joined intervals by length.
// ============================================================================
// Every accepted word produces exactly one output word, in order. The block
// takes one word per clock while the output is not stalled: a word sits in
// the input register, the join decision, length filter and counter updates
// are worked out from it and the held-interval state in a single pass, and
// the result lands in the output register. The input side keeps accepting
// while a result waits on a stalled output, until both registers are full.
// Interval words (tuser 0) update the held interval, or with a join distance
// of zero are closed and filtered at once; a flush word (tuser 1) closes the
// held interval at the end of a stream. When the output tuser bit is set, the
// record fields carry an accepted interval with its line number; otherwise
// they read zero. The four counters are reported in every word and saturate
// at all ones.
// Configuration must be written only while no word is in flight.
module genomic_interval_joiner #(
    parameter int CHROM_ID_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [gij_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gij_pkg::CFG_DAT_W-1:0]       cfg_data,
    // Input stream.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: chrom_id[15:0], start_pos[46:16], end_pos[77:47], zero pad.
    input  logic [gij_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // tuser: func (0 = interval, 1 = flush).
    input  logic                                s_axis_tuser,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: line_number[31:0], out_chrom[47:32], out_start[78:48],
    // out_end[109:79], out_length[142:110], inputs_seen[174:143],
    // closed_count[206:175], short_rejects[238:207], long_rejects[270:239],
    // zero pad.
    output logic [gij_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // tuser: record_valid.
    output logic                                m_axis_tuser
);
    import gij_pkg::*;

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t core_res;
    logic    advance;

    // Configuration registers; writes to an unused index are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.join_distance     <= JOIN_DISTANCE_RST;
            cfg_reg.min_merged_length <= MIN_LENGTH_RST;
            cfg_reg.max_merged_length <= MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_JOIN_DISTANCE: cfg_reg.join_distance     <= cfg_data[JOIN_W-1:0];
                CFG_MIN_LENGTH:    cfg_reg.min_merged_length <= cfg_data[FILT_W-1:0];
                CFG_MAX_LENGTH:    cfg_reg.max_merged_length <= cfg_data[FILT_W-1:0];
                default:           cfg_reg                   <= cfg_reg;
            endcase
        end
    end

    // The held word moves on whenever the output register is free or being
    // emptied in this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.func <= s_axis_tuser;
            in_item_reg.data <= s_axis_tdata[$bits(in_data_t)-1:0];
        end
    end

    gij_core #(
        .CHROM_ID_BITS (CHROM_ID_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.record_valid;
    assign m_axis_tdata  = OUT_DATA_W'(out_res_reg.data);

endmodule

>>> bench/genomic_interval_joiner_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// genomic_interval_joiner_tb
// Self-checking bench for the interval joiner. Interval and flush words are
// streamed in under random idling and back-pressure. A predictor in the bench
// tracks the held interval, the length filter and the counters, and every
// output word is compared field by field with the oldest expected word.
// ============================================================================
module genomic_interval_joiner_tb;

    import gij_pkg::*;

    localparam int CHROM_BITS  = 16;
    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_WORDS = 112;
    localparam int NUM_PHASES  = 8;
    localparam int LONG_HOLD   = 300;

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // tdata: chrom_id, start_pos, end_pos, zero pad (lowest bit first).
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // tuser: func.
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // tdata: line_number, out_chrom, out_start, out_end, out_length,
    // inputs_seen, closed_count, short_rejects, long_rejects, zero pad.
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // tuser: record_valid.
    logic                  m_axis_tuser;

    genomic_interval_joiner #(
        .CHROM_ID_BITS (CHROM_BITS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    item_t   pending_words[$];   // words waiting for the driver
    result_t expected_words[$];  // predicted output words, oldest first
    int      words_queued = 0;   // every word handed to the driver so far
    int      words_checked = 0;  // every output word that completed a handshake
    int      mismatches = 0;
    int      cycle_count = 0;
    logic    calm = 1'b0;        // set for the tail of the run: no idling at all
    int      tx_gap = 0;
    int      rx_stall = 0;
    int      rx_words = 0;

    // Register copies as the block should see them.
    logic [JOIN_W-1:0] join_dist = JOIN_DISTANCE_RST;
    logic [FILT_W-1:0] min_len   = MIN_LENGTH_RST;
    logic [FILT_W-1:0] max_len   = MAX_LENGTH_RST;

    // Predicted joiner state: the open interval and the four counters plus the
    // running line number of accepted records.
    logic               held_valid = 1'b0;
    logic [CHROM_W-1:0] held_chrom = '0;
    logic [POS_W-1:0]   held_start = '0;
    logic [POS_W-1:0]   held_end = '0;
    logic [CNT_W-1:0]   n_inputs = '0;
    logic [CNT_W-1:0]   n_closed = '0;
    logic [CNT_W-1:0]   n_short = '0;
    logic [CNT_W-1:0]   n_long = '0;
    logic [CNT_W-1:0]   n_accepted = '0;

    // Cursor of the sorted stream that the generator walks along.
    logic [CHROM_W-1:0] gen_chrom = '0;
    longint             gen_pos = 0;

    // ------------------------------------------------------------------------
    // Predictor.
    // ------------------------------------------------------------------------
    function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Closes one interval: it is counted, then filtered on its signed length.
    // The too-short test wins over the too-long test, so an inverted interval
    // always lands in the short count unless the minimum is zero and the end lies just before the start.
    function automatic void close_interval(input logic [CHROM_W-1:0] c,
                                           input logic [POS_W-1:0] s,
                                           input logic [POS_W-1:0] e,
                                           inout result_t r);
        longint span;
        span = longint'(e) - longint'(s) + 1;
        n_closed = bump(n_closed);
        if (span < longint'(min_len))
            n_short = bump(n_short);
        else if (span > longint'(max_len))
            n_long = bump(n_long);
        else
        begin
            n_accepted = bump(n_accepted);
            r.record_valid     = 1'b1;
            r.data.line_number = n_accepted;
            r.data.out_chrom   = c;
            r.data.out_start   = s;
            r.data.out_end     = e;
            r.data.out_length  = span[LEN_W-1:0];
        end
    endfunction

    // Works out the output word for one accepted input word.
    function automatic result_t join_step(input item_t w);
        result_t            r;
        logic [CHROM_W-1:0] c;
        logic [POS_W-1:0]   s;
        logic [POS_W-1:0]   e;
        r = '0;
        c = w.data.chrom_id & CHROM_W'((64'd1 << CHROM_BITS) - 1);
        s = w.data.start_pos;
        e = w.data.end_pos;
        if (w.func == FUNC_FLUSH)
        begin
            // A flush closes the held interval whatever the join distance is
            // now; with nothing held it changes nothing.
            if (held_valid)
            begin
                close_interval(held_chrom, held_start, held_end, r);
                held_valid = 1'b0;
            end
        end
        else
        begin
            n_inputs = bump(n_inputs);
            if (join_dist == '0)
                close_interval(c, s, e, r);
            else if (!held_valid)
            begin
                held_valid = 1'b1;
                held_chrom = c;
                held_start = s;
                held_end   = e;
            end
            else if (c != held_chrom ||
                     longint'(s) - longint'(held_end) - 1 > longint'(join_dist))
            begin
                close_interval(held_chrom, held_start, held_end, r);
                held_chrom = c;
                held_start = s;
                held_end   = e;
            end
            else
                held_end = e;  // the new end replaces the held one, even if smaller
        end
        r.data.inputs_seen   = n_inputs;
        r.data.closed_count  = n_closed;
        r.data.short_rejects = n_short;
        r.data.long_rejects  = n_long;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic item_t make_word(input logic f, input logic [31:0] c,
                                        input logic [31:0] s, input logic [31:0] e);
        item_t w;
        w.func           = f;
        w.data.chrom_id  = c[CHROM_W-1:0];
        w.data.start_pos = s[POS_W-1:0];
        w.data.end_pos   = e[POS_W-1:0];
        return w;
    endfunction

    // Mostly well-formed sorted streams whose gaps and lengths sit around the
    // join distance and the filter limits; the rest is flushes and noise.
    function automatic item_t random_word();
        item_t       w;
        logic [95:0] raw;
        longint      s;
        longint      e;
        longint      gap;
        longint      span;
        int          pick;
        raw  = {$urandom(), $urandom(), $urandom()};
        w.data = raw[$bits(in_data_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            w.func = FUNC_FLUSH;
            return w;
        end
        w.func = FUNC_INTERVAL;
        if (pick < 16)
            return w;
        if (gen_pos > 64'h7000_0000 || $urandom_range(0, 15) == 0)
        begin
            gen_chrom = ($urandom_range(0, 3) == 0) ? CHROM_W'($urandom()) : gen_chrom + 1'b1;
            gen_pos   = $urandom_range(0, 1000);
        end
        case ($urandom_range(0, 5))
            0:       gap = -longint'($urandom_range(0, 50));
            1:       gap = $urandom_range(0, join_dist);
            2:       gap = join_dist;
            3:       gap = longint'(join_dist) + 1;
            4:       gap = longint'(join_dist) + $urandom_range(2, 5000);
            default: gap = $urandom_range(0, 200);
        endcase
        case ($urandom_range(0, 5))
            0:       span = longint'(min_len) + $urandom_range(0, 2) - 1;
            1:       span = longint'(max_len) + $urandom_range(0, 2) - 1;
            2:       span = $urandom_range(1, 300);
            3:       span = -longint'($urandom_range(0, 20));
            default: span = $urandom_range(1, 5000);
        endcase
        s = gen_pos + gap + 1;
        if (s < 0)
            s = 0;
        if (s > 64'h7FFF_FFFF)
            s = 64'h7FFF_FFFF;
        e = s + span - 1;
        if (e < 0)
            e = 0;
        if (e > 64'h7FFF_FFFF)
            e = 64'h7FFF_FFFF;
        if (e > gen_pos)
            gen_pos = e;
        w.data.chrom_id  = gen_chrom;
        w.data.start_pos = s[POS_W-1:0];
        w.data.end_pos   = e[POS_W-1:0];
        return w;
    endfunction

    task automatic queue_word(input item_t w);
        pending_words.push_back(w);
        words_queued++;
    endtask

    // Waits until every queued word has come back, then lets the pipeline
    // drain a little further. Sampled on the falling edge to stay clear of
    // the clocked processes.
    task automatic settle();
        while (words_checked != words_queued)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_JOIN_DISTANCE: join_dist = val[JOIN_W-1:0];
            CFG_MIN_LENGTH:    min_len = val;
            CFG_MAX_LENGTH:    max_len = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("Mismatch: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
            note_mismatch($sformatf("word %0d %s expected %0h got %0h",
                                    words_checked, name, want, got));
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver. A new word is offered only once the previous one was taken, so
    // tvalid never drops while a word is waiting. Idle bursts are dropped in
    // between until the calm tail.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : driver
        item_t w;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (tx_gap != 0)
            begin
                tx_gap        <= tx_gap - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                tx_gap        <= $urandom_range(0, 14);
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_words.size() != 0)
            begin
                w = pending_words.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= IN_DATA_W'(w.data);
                s_axis_tuser  <= w.func;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Random stall bursts, and twice a long hold-off so the block
    // fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : receiver
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_words <= rx_words + 1;
            if (rx_stall != 0)
            begin
                rx_stall      <= rx_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && m_axis_tvalid && m_axis_tready &&
                     (rx_words == 250 || rx_words == 550))
            begin
                rx_stall      <= LONG_HOLD;
                m_axis_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                rx_stall      <= $urandom_range(0, 14);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Output words are checked against the oldest expectation; input
    // handshakes feed the predictor. Both use values sampled at the edge.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        result_t   want;
        out_data_t got;
        item_t     taken;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(out_data_t)-1:0];
                if (expected_words.size() == 0)
                    note_mismatch($sformatf("word %0d arrived with nothing expected",
                                            words_checked));
                else
                begin
                    want = expected_words.pop_front();
                    compare_field("record_valid", want.record_valid, m_axis_tuser);
                    compare_field("line_number", want.data.line_number, got.line_number);
                    compare_field("out_chrom", want.data.out_chrom, got.out_chrom);
                    compare_field("out_start", want.data.out_start, got.out_start);
                    compare_field("out_end", want.data.out_end, got.out_end);
                    compare_field("out_length", want.data.out_length, got.out_length);
                    compare_field("inputs_seen", want.data.inputs_seen, got.inputs_seen);
                    compare_field("closed_count", want.data.closed_count,
                                  got.closed_count);
                    compare_field("short_rejects", want.data.short_rejects,
                                  got.short_rejects);
                    compare_field("long_rejects", want.data.long_rejects,
                                  got.long_rejects);
                end
                words_checked <= words_checked + 1;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.func = s_axis_tuser;
                taken.data = s_axis_tdata[$bits(in_data_t)-1:0];
                expected_words.push_back(join_step(taken));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin : sequencer
        logic [CFG_DAT_W-1:0] jd_val;
        logic [CFG_DAT_W-1:0] lo_val;
        logic [CFG_DAT_W-1:0] hi_val;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Filter edges with the reset settings: no joining, min 4, max 1000000.
        queue_word(make_word(FUNC_INTERVAL, 1, 100, 103));           // exactly min
        queue_word(make_word(FUNC_INTERVAL, 1, 200, 202));           // one short
        queue_word(make_word(FUNC_INTERVAL, 1, 1000, 1000999));      // exactly max
        queue_word(make_word(FUNC_INTERVAL, 1, 1000, 1001000));      // one over max
        queue_word(make_word(FUNC_INTERVAL, 32'hFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        queue_word(make_word(FUNC_INTERVAL, 2, 0, 32'h7FFF_FFFF));   // longest span
        queue_word(make_word(FUNC_INTERVAL, 2, 500, 400));           // inverted
        queue_word(make_word(FUNC_FLUSH, 0, 0, 0));                  // nothing held
        settle();

        // With a zero minimum an empty interval passes, a negative one does not.
        set_reg(CFG_MIN_LENGTH, '0);
        set_reg(CFG_MAX_LENGTH, '1);
        @(negedge clk);
        queue_word(make_word(FUNC_INTERVAL, 3, 10, 9));
        queue_word(make_word(FUNC_INTERVAL, 3, 10, 8));
        settle();

        // Joining at distance 10: gap of exactly 10 joins, an overlap pulls the
        // end back, a gap of 11 and a chromosome change both close.
        set_reg(CFG_JOIN_DISTANCE, 10);
        @(negedge clk);
        queue_word(make_word(FUNC_INTERVAL, 5, 100, 200));
        queue_word(make_word(FUNC_INTERVAL, 5, 211, 300));
        queue_word(make_word(FUNC_INTERVAL, 5, 250, 260));
        queue_word(make_word(FUNC_INTERVAL, 5, 272, 280));
        queue_word(make_word(FUNC_INTERVAL, 6, 281, 290));
        queue_word(make_word(FUNC_FLUSH, 0, 0, 0));
        queue_word(make_word(FUNC_FLUSH, 0, 0, 0));
        queue_word(make_word(FUNC_INTERVAL, 7, 0, 0));               // left open
        settle();

        // The interval left open is still closed by a flush once joining is off.
        set_reg(CFG_JOIN_DISTANCE, 0);
        @(negedge clk);
        queue_word(make_word(FUNC_FLUSH, 0, 0, 0));
        queue_word(make_word(FUNC_INTERVAL, 7, 5, 6));
        settle();

        // Random phases, each under its own register setting.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: begin jd_val = 1000;     lo_val = 4;        hi_val = 1000000;  end
                1: begin jd_val = '1;       lo_val = 0;        hi_val = '1;       end
                2: begin jd_val = 1;        lo_val = 1;        hi_val = 500;      end
                3: begin jd_val = 0;        lo_val = 0;        hi_val = 0;        end
                4: begin jd_val = 1000000;  lo_val = 10000000; hi_val = 10000000; end
                5:
                begin
                    jd_val = $urandom_range(1, 5000);
                    lo_val = $urandom_range(0, 2000);
                    hi_val = $urandom_range(2000, 200000);
                end
                6:
                begin
                    jd_val = CFG_DAT_W'($urandom());
                    lo_val = CFG_DAT_W'($urandom());
                    hi_val = CFG_DAT_W'($urandom());
                end
                default: begin jd_val = 50; lo_val = 4; hi_val = 100000; end
            endcase
            // The last phase runs without any idling on either side.
            if (p == NUM_PHASES - 1)
            begin
                @(posedge clk);
                calm <= 1'b1;
            end
            set_reg(CFG_JOIN_DISTANCE, jd_val);
            set_reg(CFG_MIN_LENGTH, lo_val);
            set_reg(CFG_MAX_LENGTH, hi_val);
            @(negedge clk);
            repeat (PHASE_WORDS) queue_word(random_word());
            settle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> genomic_interval_joiner.f
hdl/gij_pkg.sv
hdl/gij_core.sv
hdl/genomic_interval_joiner.sv
bench/genomic_interval_joiner_tb.sv
